// ===== src/dqpi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqpi_pkg
// Types, register map, microcode and saturation helpers of the dq cascaded
// PI voltage controller.
// ----------------------------------------------------------------------------
package dqpi_pkg;

	// register map, index of the 32-bit word on the configuration port
	localparam logic [2:0] REG_GAIN_VOLT_PROP = 3'd0;
	localparam logic [2:0] REG_GAIN_VOLT_INT  = 3'd1;
	localparam logic [2:0] REG_GAIN_CURR_PROP = 3'd2;
	localparam logic [2:0] REG_GAIN_CURR_INT  = 3'd3;
	localparam logic [2:0] REG_VOLT_REF_D     = 3'd4;
	localparam logic [2:0] REG_VOLT_REF_Q     = 3'd5;
	localparam logic [2:0] REG_STEP_SECONDS   = 3'd6;

	localparam logic [31:0] STEP_SECONDS_RST  = 32'd214748;

	localparam int          ACC_W      = 120;
	localparam int          PROD_W     = 114;
	localparam int          COEF_W     = 49;
	localparam logic [5:0]  AXIS_START = 6'd7;

	typedef enum logic [3:0] {
		UOP_CLR,
		UOP_MAC,
		UOP_LOAD,
		UOP_SHR16,
		UOP_WB,
		UOP_DIV,
		UOP_COEF,
		UOP_PREV,
		UOP_AXIS,
		UOP_DONE
	} uop_op_t;

	typedef enum logic [3:0] {
		X_VR,
		X_VC,
		X_VO,
		X_CUR,
		X_IO,
		X_RO,
		X_IREF,
		X_PHI,
		X_GAM,
		X_XS,
		X_KIV,
		X_KIC
	} xsel_t;

	typedef enum logic [2:0] {
		Y_DT,
		Y_KIV,
		Y_KIC,
		Y_KA,
		Y_KB,
		Y_KB2,
		Y_KC,
		Y_KD
	} ysel_t;

	typedef enum logic [2:0] {
		D_NONE,
		D_KIVDT,
		D_KICDT,
		D_IREF,
		D_PHI,
		D_GAM,
		D_XS,
		D_VH
	} dest_t;

	typedef enum logic [1:0] {
		W_ALL,
		W_STEP,
		W_INIT
	} when_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_WAIT,
		ST_DONE
	} ctrl_state_t;

	typedef struct packed {
		uop_op_t op;
		xsel_t   xsel;
		ysel_t   ysel;
		logic    sub;
		dest_t   dest;
		when_t   when_run;
	} uop_t;

	typedef struct packed {
		logic    capture;
		logic    exec;
		uop_op_t op;
		xsel_t   xsel;
		ysel_t   ysel;
		logic    sub;
		dest_t   dest;
		logic    axis;
		logic    init;
		logic    out_load;
	} cmd_t;

	typedef struct packed {
		logic mul_done;
		logic div_done;
	} sts_t;

	function automatic uop_t mk(input uop_op_t op, input xsel_t x, input ysel_t y,
		input logic sub, input dest_t d, input when_t w);
		uop_t u;
		u.op       = op;
		u.xsel     = x;
		u.ysel     = y;
		u.sub      = sub;
		u.dest     = d;
		u.when_run = w;
		return u;
	endfunction

	// microprogram: coefficients once, then the axis body run for d and q
	function automatic uop_t uop_rom(input logic [5:0] pc);
		uop_t u;
		case (pc)
			6'd0:  u = mk(UOP_CLR,   X_VR,   Y_DT,  1'b0, D_NONE,  W_ALL);
			6'd1:  u = mk(UOP_MAC,   X_KIV,  Y_DT,  1'b0, D_NONE,  W_ALL);
			6'd2:  u = mk(UOP_WB,    X_VR,   Y_DT,  1'b0, D_KIVDT, W_ALL);
			6'd3:  u = mk(UOP_CLR,   X_VR,   Y_DT,  1'b0, D_NONE,  W_ALL);
			6'd4:  u = mk(UOP_MAC,   X_KIC,  Y_DT,  1'b0, D_NONE,  W_ALL);
			6'd5:  u = mk(UOP_WB,    X_VR,   Y_DT,  1'b0, D_KICDT, W_ALL);
			6'd6:  u = mk(UOP_COEF,  X_VR,   Y_DT,  1'b0, D_NONE,  W_ALL);
			// axis body
			6'd7:  u = mk(UOP_DIV,   X_VR,   Y_DT,  1'b0, D_PHI,   W_INIT);
			6'd8:  u = mk(UOP_DIV,   X_VR,   Y_DT,  1'b0, D_GAM,   W_INIT);
			6'd9:  u = mk(UOP_CLR,   X_VR,   Y_DT,  1'b0, D_NONE,  W_ALL);
			6'd10: u = mk(UOP_MAC,   X_VR,   Y_KB2, 1'b0, D_NONE,  W_ALL);
			6'd11: u = mk(UOP_MAC,   X_VC,   Y_KB,  1'b1, D_NONE,  W_ALL);
			6'd12: u = mk(UOP_MAC,   X_VO,   Y_KC,  1'b1, D_NONE,  W_ALL);
			6'd13: u = mk(UOP_MAC,   X_PHI,  Y_KIV, 1'b0, D_NONE,  W_ALL);
			6'd14: u = mk(UOP_WB,    X_VR,   Y_DT,  1'b0, D_IREF,  W_ALL);
			6'd15: u = mk(UOP_LOAD,  X_PHI,  Y_DT,  1'b0, D_NONE,  W_STEP);
			6'd16: u = mk(UOP_MAC,   X_VR,   Y_DT,  1'b0, D_NONE,  W_STEP);
			6'd17: u = mk(UOP_MAC,   X_VR,   Y_DT,  1'b0, D_NONE,  W_STEP);
			6'd18: u = mk(UOP_MAC,   X_VC,   Y_DT,  1'b1, D_NONE,  W_STEP);
			6'd19: u = mk(UOP_MAC,   X_VO,   Y_DT,  1'b1, D_NONE,  W_STEP);
			6'd20: u = mk(UOP_WB,    X_VR,   Y_DT,  1'b0, D_PHI,   W_STEP);
			6'd21: u = mk(UOP_LOAD,  X_GAM,  Y_DT,  1'b0, D_NONE,  W_STEP);
			6'd22: u = mk(UOP_MAC,   X_IREF, Y_DT,  1'b0, D_NONE,  W_STEP);
			6'd23: u = mk(UOP_MAC,   X_CUR,  Y_DT,  1'b1, D_NONE,  W_STEP);
			6'd24: u = mk(UOP_MAC,   X_RO,   Y_DT,  1'b0, D_NONE,  W_STEP);
			6'd25: u = mk(UOP_MAC,   X_IO,   Y_DT,  1'b1, D_NONE,  W_STEP);
			6'd26: u = mk(UOP_WB,    X_VR,   Y_DT,  1'b0, D_GAM,   W_STEP);
			6'd27: u = mk(UOP_CLR,   X_VR,   Y_DT,  1'b0, D_NONE,  W_ALL);
			6'd28: u = mk(UOP_MAC,   X_VR,   Y_KB2, 1'b0, D_NONE,  W_ALL);
			6'd29: u = mk(UOP_MAC,   X_VC,   Y_KC,  1'b1, D_NONE,  W_ALL);
			6'd30: u = mk(UOP_MAC,   X_PHI,  Y_KIV, 1'b0, D_NONE,  W_ALL);
			6'd31: u = mk(UOP_WB,    X_VR,   Y_DT,  1'b0, D_XS,    W_ALL);
			6'd32: u = mk(UOP_CLR,   X_VR,   Y_DT,  1'b0, D_NONE,  W_ALL);
			6'd33: u = mk(UOP_MAC,   X_XS,   Y_KA,  1'b0, D_NONE,  W_ALL);
			6'd34: u = mk(UOP_SHR16, X_VR,   Y_DT,  1'b0, D_NONE,  W_ALL);
			6'd35: u = mk(UOP_MAC,   X_IREF, Y_KD,  1'b0, D_NONE,  W_ALL);
			6'd36: u = mk(UOP_MAC,   X_CUR,  Y_KD,  1'b1, D_NONE,  W_ALL);
			6'd37: u = mk(UOP_MAC,   X_GAM,  Y_KIC, 1'b0, D_NONE,  W_ALL);
			6'd38: u = mk(UOP_WB,    X_VR,   Y_DT,  1'b0, D_VH,    W_ALL);
			6'd39: u = mk(UOP_PREV,  X_VR,   Y_DT,  1'b0, D_NONE,  W_ALL);
			6'd40: u = mk(UOP_AXIS,  X_VR,   Y_DT,  1'b0, D_NONE,  W_ALL);
			default: u = mk(UOP_DONE, X_VR,  Y_DT,  1'b0, D_NONE,  W_ALL);
		endcase
		return u;
	endfunction

	// clamp to a signed width; top bit of the result flags a clamp
	function automatic logic [32:0] sat32(input logic signed [ACC_W-1:0] v);
		logic [32:0] r;
		if ((&v[ACC_W-1:31]) || !(|v[ACC_W-1:31])) r = {1'b0, v[31:0]};
		else if (v[ACC_W-1]) r = {1'b1, 32'h8000_0000};
		else r = {1'b1, 32'h7fff_ffff};
		return r;
	endfunction

	function automatic logic [48:0] sat48(input logic signed [ACC_W-1:0] v);
		logic [48:0] r;
		if ((&v[ACC_W-1:47]) || !(|v[ACC_W-1:47])) r = {1'b0, v[47:0]};
		else if (v[ACC_W-1]) r = {1'b1, 48'h8000_0000_0000};
		else r = {1'b1, 48'h7fff_ffff_ffff};
		return r;
	endfunction

	function automatic logic [64:0] sat64(input logic signed [ACC_W-1:0] v);
		logic [64:0] r;
		if ((&v[ACC_W-1:63]) || !(|v[ACC_W-1:63])) r = {1'b0, v[63:0]};
		else if (v[ACC_W-1]) r = {1'b1, 64'h8000_0000_0000_0000};
		else r = {1'b1, 64'h7fff_ffff_ffff_ffff};
		return r;
	endfunction

endpackage

// ===== src/dq_cascaded_pi_voltage_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_cascaded_pi_voltage_controller
// Two-axis cascaded PI voltage/current controller with trapezoidal
// integrators, fixed point, APB register file.
// ----------------------------------------------------------------------------
// The block takes one item at a time, a step beat (action 0) or an init
// beat (action 1). Every product goes through one shared multiplier that
// eats a 16-bit digit of the coefficient per cycle (40 multiply-accumulates
// per step, 24 per init), and the init seeding goes through one restoring
// divider at one quotient bit per cycle (four divides per init; a divide
// with a zero gain skips the bit loop). in_ready is high only while no
// item is in flight; a finished result sits in its own register, so the
// next item is taken while that result still waits.
// Registers lie at byte addresses 4*i: gains Kpv, Kiv, Kpc, Kic (unsigned
// Q16.16), references d and q (signed Q15.16) and the time step (Q0.32).
// Change them only while the block is idle. fault reports any clamp or zero
// divisor seen during that item.
// ----------------------------------------------------------------------------
module dq_cascaded_pi_voltage_controller (
	input  logic               clk,
	input  logic               arst_n,
	// configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// input channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               action,
	input  logic signed [31:0] vcap_d,
	input  logic signed [31:0] vcap_q,
	input  logic signed [31:0] ifilt_d,
	input  logic signed [31:0] ifilt_q,
	input  logic signed [31:0] vsrc_init_d,
	input  logic signed [31:0] vsrc_init_q,
	// result channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] vhist_d,
	output logic signed [31:0] vhist_q,
	output logic               fault
);

	logic [31:0] gain_volt_prop_q;
	logic [31:0] gain_volt_int_q;
	logic [31:0] gain_curr_prop_q;
	logic [31:0] gain_curr_int_q;
	logic [31:0] volt_ref_d_q;
	logic [31:0] volt_ref_q_q;
	logic [31:0] step_seconds_q;
	logic        wr_en;

	dqpi_pkg::cmd_t cmd;
	dqpi_pkg::sts_t sts;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// register file; writes to unused words drop silently
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_volt_prop_q <= '0;
			gain_volt_int_q  <= '0;
			gain_curr_prop_q <= '0;
			gain_curr_int_q  <= '0;
			volt_ref_d_q     <= '0;
			volt_ref_q_q     <= '0;
			step_seconds_q   <= dqpi_pkg::STEP_SECONDS_RST;
		end else if (wr_en) begin
			case (paddr[4:2])
				dqpi_pkg::REG_GAIN_VOLT_PROP: gain_volt_prop_q <= pwdata;
				dqpi_pkg::REG_GAIN_VOLT_INT:  gain_volt_int_q  <= pwdata;
				dqpi_pkg::REG_GAIN_CURR_PROP: gain_curr_prop_q <= pwdata;
				dqpi_pkg::REG_GAIN_CURR_INT:  gain_curr_int_q  <= pwdata;
				dqpi_pkg::REG_VOLT_REF_D:     volt_ref_d_q     <= pwdata;
				dqpi_pkg::REG_VOLT_REF_Q:     volt_ref_q_q     <= pwdata;
				dqpi_pkg::REG_STEP_SECONDS:   step_seconds_q   <= pwdata;
				default:                      step_seconds_q   <= step_seconds_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			dqpi_pkg::REG_GAIN_VOLT_PROP: prdata = gain_volt_prop_q;
			dqpi_pkg::REG_GAIN_VOLT_INT:  prdata = gain_volt_int_q;
			dqpi_pkg::REG_GAIN_CURR_PROP: prdata = gain_curr_prop_q;
			dqpi_pkg::REG_GAIN_CURR_INT:  prdata = gain_curr_int_q;
			dqpi_pkg::REG_VOLT_REF_D:     prdata = volt_ref_d_q;
			dqpi_pkg::REG_VOLT_REF_Q:     prdata = volt_ref_q_q;
			dqpi_pkg::REG_STEP_SECONDS:   prdata = step_seconds_q;
			default:                      prdata = '0;
		endcase
	end

	// sequencer: fetch microcode, wait on the shared units, deliver the beat
	dqpi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: both loops of both axes on one multiplier and one divider
	dqpi_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.gain_volt_prop (gain_volt_prop_q),
		.gain_volt_int  (gain_volt_int_q),
		.gain_curr_prop (gain_curr_prop_q),
		.gain_curr_int  (gain_curr_int_q),
		.volt_ref_d     ($signed(volt_ref_d_q)),
		.volt_ref_q     ($signed(volt_ref_q_q)),
		.step_seconds   (step_seconds_q),
		.vcap_d         (vcap_d),
		.vcap_q         (vcap_q),
		.ifilt_d        (ifilt_d),
		.ifilt_q        (ifilt_q),
		.vsrc_init_d    (vsrc_init_d),
		.vsrc_init_q    (vsrc_init_q),
		.vhist_d        (vhist_d),
		.vhist_q        (vhist_q),
		.fault          (fault)
	);

endmodule

// ===== src/dqpi_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqpi_mul
// Sequential signed-by-unsigned multiplier, one 16-bit digit of y a cycle.
// ----------------------------------------------------------------------------
module dqpi_mul (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [63:0]                   x,
	input  logic [dqpi_pkg::COEF_W-1:0]          y,
	output logic                                 done,
	output logic signed [dqpi_pkg::PROD_W-1:0]   prod
);

	logic [63:0]                     xmag_q;
	logic                            neg_q;
	logic [63:0]                     y_q;
	logic [112:0]                    pm_q;
	logic [1:0]                      cnt_q;
	logic                            busy_q;
	logic                            done_q;
	logic [15:0]                     ydig;
	logic [79:0]                     part;
	logic [112:0]                    part_sh;

	assign ydig    = y_q[{cnt_q, 4'b0000} +: 16];
	assign part    = xmag_q * ydig;
	assign part_sh = 113'({33'b0, part} << {cnt_q, 4'b0000});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			xmag_q <= x[63] ? 64'(-x) : x;
			neg_q  <= x[63];
			y_q    <= {{(64 - dqpi_pkg::COEF_W){1'b0}}, y};
			pm_q   <= '0;
		end else if (busy_q) begin
			pm_q <= pm_q + part_sh;
		end
	end

	assign done = done_q;
	assign prod = neg_q ? -$signed({1'b0, pm_q}) : $signed({1'b0, pm_q});

endmodule

// ===== src/dqpi_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqpi_div
// Restoring divider for integrator seeding: num * 2^32 / k, one bit a cycle.
// ----------------------------------------------------------------------------
module dqpi_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [32:0] num,
	input  logic [31:0]        k,
	output logic               done,
	output logic signed [47:0] quot,
	output logic               flag
);

	logic [64:0] dvd_q;
	logic [31:0] rem_q;
	logic [64:0] quo_q;
	logic [31:0] k_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic        neg_q;
	logic        kz_q;
	logic [32:0] trial;
	logic        ge;
	logic [32:0] diff;
	logic signed [65:0] sval;
	logic [48:0] sres;

	assign trial = {rem_q, dvd_q[64]};
	assign ge    = trial >= {1'b0, k_q};
	assign diff  = trial - {1'b0, k_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= (k != 32'd0);
				done_q <= (k == 32'd0);
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd64) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[32];
			dvd_q <= {(num[32] ? 33'(-num) : num), 32'b0};
			rem_q <= '0;
			quo_q <= '0;
			k_q   <= k;
			kz_q  <= (k == 32'd0);
		end else if (busy_q) begin
			dvd_q <= {dvd_q[63:0], 1'b0};
			rem_q <= ge ? diff[31:0] : trial[31:0];
			quo_q <= {quo_q[63:0], ge};
		end
	end

	assign sval = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
	assign sres = dqpi_pkg::sat48({{(dqpi_pkg::ACC_W - 66){sval[65]}}, sval});

	assign done = done_q;
	assign quot = kz_q ? 48'sd0 : $signed(sres[47:0]);
	assign flag = kz_q | sres[48];

endmodule

// ===== src/dqpi_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqpi_dp
// Datapath: operand selection, shared multiplier and divider, accumulator,
// integrators and stored samples of both axes.
// ----------------------------------------------------------------------------
module dqpi_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  dqpi_pkg::cmd_t      cmd,
	output dqpi_pkg::sts_t      sts,
	input  logic [31:0]         gain_volt_prop,
	input  logic [31:0]         gain_volt_int,
	input  logic [31:0]         gain_curr_prop,
	input  logic [31:0]         gain_curr_int,
	input  logic signed [31:0]  volt_ref_d,
	input  logic signed [31:0]  volt_ref_q,
	input  logic [31:0]         step_seconds,
	input  logic signed [31:0]  vcap_d,
	input  logic signed [31:0]  vcap_q,
	input  logic signed [31:0]  ifilt_d,
	input  logic signed [31:0]  ifilt_q,
	input  logic signed [31:0]  vsrc_init_d,
	input  logic signed [31:0]  vsrc_init_q,
	output logic signed [31:0]  vhist_d,
	output logic signed [31:0]  vhist_q,
	output logic                fault
);

	localparam int AW = dqpi_pkg::ACC_W;
	localparam int CW = dqpi_pkg::COEF_W;

	logic signed [31:0] vc_q [2];
	logic signed [31:0] cur_q [2];
	logic signed [31:0] vs_q [2];
	logic signed [31:0] vcap_prev_q [2];
	logic signed [31:0] ifilt_prev_q [2];
	logic signed [31:0] iref_prev_q [2];
	logic signed [31:0] vh_q [2];
	logic signed [47:0] phi_q [2];
	logic signed [47:0] gam_q [2];
	logic signed [31:0] iref_q;
	logic signed [63:0] xs_q;
	logic [63:0]        kivdt_q;
	logic [63:0]        kicdt_q;
	logic [CW-1:0]      ka_q, kb_q, kb2_q, kc_q, kd_q;
	logic signed [AW-1:0] acc_q;
	logic               fault_q;

	logic               ax;
	logic signed [31:0] vr;
	logic signed [63:0] xop;
	logic [CW-1:0]      yop;
	logic               mul_done;
	logic signed [dqpi_pkg::PROD_W-1:0] prod;
	logic signed [AW-1:0] prod_ext;
	logic               div_start;
	logic signed [32:0] div_num;
	logic [31:0]        div_k;
	logic               div_done;
	logic signed [47:0] div_q;
	logic               div_flag;
	logic [32:0]        r32;
	logic [48:0]        r48;
	logic [64:0]        r64;
	logic               wb;
	logic               wb_flag;
	logic               fault_set;

	assign ax = cmd.axis;
	assign vr = ax ? volt_ref_q : volt_ref_d;

	always_comb begin
		case (cmd.xsel)
			dqpi_pkg::X_VR:   xop = 64'(vr);
			dqpi_pkg::X_VC:   xop = 64'(vc_q[ax]);
			dqpi_pkg::X_VO:   xop = cmd.init ? 64'(vc_q[ax]) : 64'(vcap_prev_q[ax]);
			dqpi_pkg::X_CUR:  xop = 64'(cur_q[ax]);
			dqpi_pkg::X_IO:   xop = 64'(ifilt_prev_q[ax]);
			dqpi_pkg::X_RO:   xop = 64'(iref_prev_q[ax]);
			dqpi_pkg::X_IREF: xop = 64'(iref_q);
			dqpi_pkg::X_PHI:  xop = 64'(phi_q[ax]);
			dqpi_pkg::X_GAM:  xop = 64'(gam_q[ax]);
			dqpi_pkg::X_XS:   xop = xs_q;
			dqpi_pkg::X_KIV:  xop = {32'b0, gain_volt_int};
			dqpi_pkg::X_KIC:  xop = {32'b0, gain_curr_int};
			default:          xop = '0;
		endcase
	end

	always_comb begin
		case (cmd.ysel)
			dqpi_pkg::Y_DT:  yop = CW'(step_seconds);
			dqpi_pkg::Y_KIV: yop = CW'(gain_volt_int);
			dqpi_pkg::Y_KIC: yop = CW'(gain_curr_int);
			dqpi_pkg::Y_KA:  yop = ka_q;
			dqpi_pkg::Y_KB:  yop = kb_q;
			dqpi_pkg::Y_KB2: yop = kb2_q;
			dqpi_pkg::Y_KC:  yop = kc_q;
			dqpi_pkg::Y_KD:  yop = kd_q;
			default:         yop = '0;
		endcase
	end

	dqpi_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.exec && (cmd.op == dqpi_pkg::UOP_MAC)),
		.x      (xop),
		.y      (yop),
		.done   (mul_done),
		.prod   (prod)
	);

	assign div_start = cmd.exec && (cmd.op == dqpi_pkg::UOP_DIV);
	assign div_num   = (cmd.dest == dqpi_pkg::D_PHI) ? 33'(cur_q[ax]) :
	                   (33'(vs_q[ax]) - 33'(vc_q[ax]));
	assign div_k     = (cmd.dest == dqpi_pkg::D_PHI) ? gain_volt_int : gain_curr_int;

	dqpi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.k      (div_k),
		.done   (div_done),
		.quot   (div_q),
		.flag   (div_flag)
	);

	assign sts.mul_done = mul_done;
	assign sts.div_done = div_done;

	assign prod_ext = AW'(prod);
	assign r32 = dqpi_pkg::sat32(acc_q >>> 32);
	assign r48 = dqpi_pkg::sat48(acc_q >>> 17);
	assign r64 = dqpi_pkg::sat64(acc_q >>> 16);
	assign wb  = cmd.exec && (cmd.op == dqpi_pkg::UOP_WB);

	always_comb begin
		case (cmd.dest)
			dqpi_pkg::D_IREF, dqpi_pkg::D_VH: wb_flag = r32[32];
			dqpi_pkg::D_PHI, dqpi_pkg::D_GAM: wb_flag = r48[48];
			dqpi_pkg::D_XS:                   wb_flag = r64[64];
			default:                          wb_flag = 1'b0;
		endcase
	end

	assign fault_set = (wb && wb_flag) || (div_done && div_flag);

	// integrators, stored samples and the fault flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				phi_q[i]        <= '0;
				gam_q[i]        <= '0;
				vcap_prev_q[i]  <= '0;
				ifilt_prev_q[i] <= '0;
				iref_prev_q[i]  <= '0;
			end
			fault_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				fault_q <= 1'b0;
			end else if (fault_set) begin
				fault_q <= 1'b1;
			end
			if (wb && (cmd.dest == dqpi_pkg::D_PHI)) phi_q[ax] <= $signed(r48[47:0]);
			if (wb && (cmd.dest == dqpi_pkg::D_GAM)) gam_q[ax] <= $signed(r48[47:0]);
			if (div_done && (cmd.dest == dqpi_pkg::D_PHI)) phi_q[ax] <= div_q;
			if (div_done && (cmd.dest == dqpi_pkg::D_GAM)) gam_q[ax] <= div_q;
			if (cmd.exec && (cmd.op == dqpi_pkg::UOP_PREV)) begin
				vcap_prev_q[ax]  <= vc_q[ax];
				ifilt_prev_q[ax] <= cmd.init ? iref_q : cur_q[ax];
				iref_prev_q[ax]  <= iref_q;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			vc_q[0]  <= vcap_d;
			vc_q[1]  <= vcap_q;
			cur_q[0] <= ifilt_d;
			cur_q[1] <= ifilt_q;
			vs_q[0]  <= vsrc_init_d;
			vs_q[1]  <= vsrc_init_q;
		end
		if (mul_done) begin
			acc_q <= cmd.sub ? (acc_q - prod_ext) : (acc_q + prod_ext);
		end else if (cmd.exec) begin
			case (cmd.op)
				dqpi_pkg::UOP_CLR:   acc_q <= '0;
				dqpi_pkg::UOP_LOAD:  acc_q <= AW'(xop) <<< 17;
				dqpi_pkg::UOP_SHR16: acc_q <= acc_q >>> 16;
				default:             acc_q <= acc_q;
			endcase
		end
		if (wb) begin
			case (cmd.dest)
				dqpi_pkg::D_KIVDT: kivdt_q   <= acc_q[63:0];
				dqpi_pkg::D_KICDT: kicdt_q   <= acc_q[63:0];
				dqpi_pkg::D_IREF:  iref_q    <= $signed(r32[31:0]);
				dqpi_pkg::D_XS:    xs_q      <= $signed(r64[63:0]);
				dqpi_pkg::D_VH:    vh_q[ax]  <= $signed(r32[31:0]);
				default:           iref_q    <= iref_q;
			endcase
		end
		if (cmd.exec && (cmd.op == dqpi_pkg::UOP_COEF)) begin
			ka_q  <= CW'({gain_curr_prop, 16'b0}) + CW'(kicdt_q >> 17);
			kb_q  <= CW'({gain_volt_prop, 16'b0}) + CW'(kivdt_q >> 17);
			kb2_q <= CW'({gain_volt_prop, 16'b0}) + CW'(kivdt_q >> 16);
			kc_q  <= CW'(kivdt_q >> 17);
			kd_q  <= CW'(kicdt_q >> 17);
		end
		if (cmd.out_load) begin
			vhist_d <= vh_q[0];
			vhist_q <= vh_q[1];
			fault   <= fault_q;
		end
	end

endmodule

// ===== src/dqpi_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqpi_ctrl
// Microcode sequencer: walks the program, waits on the shared units and
// hands the finished beat to the result register.
// ----------------------------------------------------------------------------
module dqpi_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               action,
	output logic               out_valid,
	input  logic               out_ready,
	input  dqpi_pkg::sts_t     sts,
	output dqpi_pkg::cmd_t     cmd
);

	dqpi_pkg::ctrl_state_t state_q, state_d;
	logic [5:0]            pc_q, pc_d;
	logic                  axis_q, axis_d;
	logic                  init_q;
	logic                  out_valid_q;
	dqpi_pkg::uop_t        uop;
	logic                  skip;

	assign uop  = dqpi_pkg::uop_rom(pc_q);
	assign skip = ((uop.when_run == dqpi_pkg::W_STEP) && init_q) ||
	              ((uop.when_run == dqpi_pkg::W_INIT) && !init_q);

	always_comb begin
		state_d      = state_q;
		pc_d         = pc_q;
		axis_d       = axis_q;
		cmd.capture  = 1'b0;
		cmd.exec     = 1'b0;
		cmd.op       = uop.op;
		cmd.xsel     = uop.xsel;
		cmd.ysel     = uop.ysel;
		cmd.sub      = uop.sub;
		cmd.dest     = uop.dest;
		cmd.axis     = axis_q;
		cmd.init     = init_q;
		cmd.out_load = 1'b0;
		case (state_q)
			dqpi_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					pc_d        = '0;
					axis_d      = 1'b0;
					state_d     = dqpi_pkg::ST_RUN;
				end
			end
			dqpi_pkg::ST_RUN: begin
				if (skip) begin
					pc_d = pc_q + 6'd1;
				end else begin
					case (uop.op)
						dqpi_pkg::UOP_MAC, dqpi_pkg::UOP_DIV: begin
							cmd.exec = 1'b1;
							state_d  = dqpi_pkg::ST_WAIT;
						end
						dqpi_pkg::UOP_AXIS: begin
							if (!axis_q) begin
								axis_d = 1'b1;
								pc_d   = dqpi_pkg::AXIS_START;
							end else begin
								pc_d = pc_q + 6'd1;
							end
						end
						dqpi_pkg::UOP_DONE: begin
							state_d = dqpi_pkg::ST_DONE;
						end
						default: begin
							cmd.exec = 1'b1;
							pc_d     = pc_q + 6'd1;
						end
					endcase
				end
			end
			dqpi_pkg::ST_WAIT: begin
				if (sts.mul_done || sts.div_done) begin
					pc_d    = pc_q + 6'd1;
					state_d = dqpi_pkg::ST_RUN;
				end
			end
			dqpi_pkg::ST_DONE: begin
				// hold until the result register is free
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = dqpi_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dqpi_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dqpi_pkg::ST_IDLE;
			pc_q        <= '0;
			axis_q      <= 1'b0;
			init_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pc_q    <= pc_d;
			axis_q  <= axis_d;
			if (cmd.capture) init_q <= action;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == dqpi_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ===== src/dqpi_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqpi_chk
// Port-level checks of the controller, bound to the top level.
// ----------------------------------------------------------------------------
module dqpi_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] vhist_d,
	input logic signed [31:0] vhist_q,
	input logic               fault
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(vhist_d) && $stable(vhist_q) &&
		$stable(fault))
		else $error("result beat changed while stalled");

	// an accepted item keeps the block busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again straight after an accept");

	// a fresh result only comes from a busy block
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared with no item in flight");

endmodule

bind dq_cascaded_pi_voltage_controller dqpi_chk u_dqpi_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.vhist_d   (vhist_d),
	.vhist_q   (vhist_q),
	.fault     (fault)
);
